[sv/assert_macros.svh]
// Assertion macros used by the sequencer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/i2cbs_pkg.sv]
// Types, constants and step tables for the I2C bit sequencer.
`default_nettype none

package i2cbs_pkg;

  localparam int unsigned TICK_W      = 10;
  localparam int unsigned STEP_W      = 5;
  localparam logic [TICK_W-1:0] STEP_TICKS_RESET = TICK_W'(10);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_SEND_ACK = 3'd5,
    CMD_RECV_ACK = 3'd6,
    CMD_RSVD     = 3'd7
  } cmd_t;

  // Pin action taken on the first tick of a step.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_SCL_HI,
    ACT_SCL_LO,
    ACT_SDA_HI,
    ACT_SDA_LO,
    ACT_SDA_MSB,      // drive shift register MSB, then shift left
    ACT_SDA_LSB,      // drive shift register bit 0 (ack level)
    ACT_SHIFT_IN,     // sample SDA into shift register
    ACT_SAMPLE_ACK,   // sample ack bit only
    ACT_SAMPLE_WACK   // sample ack bit and update acked
  } act_t;

  // Classified request handed from front to back.
  typedef struct packed {
    cmd_t        kind;
    logic        is_cmd;
    logic [7:0]  tx_byte;
    logic        ack_to_send;
    logic        sda_in;
  } req_t;

  // Result of one tick.
  typedef struct packed {
    logic        rejected;
    logic        ack_bit_seen;
    logic        acked;
    logic [7:0]  rx_byte;
    logic        done_res;
    logic        busy_res;
    logic        sda_level;
    logic        scl_level;
  } res_t;

  function automatic logic [STEP_W-1:0] seq_len(cmd_t cmd);
    logic [STEP_W-1:0] n;
    case (cmd)
      CMD_START:    n = STEP_W'(4);
      CMD_STOP:     n = STEP_W'(3);
      CMD_WRITE:    n = STEP_W'(28);
      CMD_READ:     n = STEP_W'(25);
      CMD_SEND_ACK: n = STEP_W'(3);
      CMD_RECV_ACK: n = STEP_W'(4);
      default:      n = '0;
    endcase
    return n;
  endfunction

  function automatic act_t ack_act(logic [1:0] ph, logic from_write);
    act_t a;
    case (ph)
      2'd0:    a = ACT_SDA_HI;
      2'd1:    a = ACT_SCL_HI;
      2'd2:    a = from_write ? ACT_SAMPLE_WACK : ACT_SAMPLE_ACK;
      default: a = ACT_SCL_LO;
    endcase
    return a;
  endfunction

  function automatic act_t step_act(cmd_t cmd, logic [STEP_W-1:0] s);
    act_t a;
    a = ACT_NONE;
    case (cmd)
      CMD_START: begin
        case (s)
          5'd0:    a = ACT_SDA_HI;
          5'd1:    a = ACT_SCL_HI;
          5'd2:    a = ACT_SDA_LO;
          default: a = ACT_SCL_LO;
        endcase
      end
      CMD_STOP: begin
        case (s)
          5'd0:    a = ACT_SDA_LO;
          5'd1:    a = ACT_SCL_HI;
          default: a = ACT_SDA_HI;
        endcase
      end
      CMD_WRITE: begin
        if (s inside {5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21})
          a = ACT_SDA_MSB;
        else if (s inside {5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22})
          a = ACT_SCL_HI;
        else if (s inside {5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23})
          a = ACT_SCL_LO;
        else
          a = ack_act(2'(s - 5'd24), 1'b1);
      end
      CMD_READ: begin
        if (s == 5'd0)
          a = ACT_SDA_HI;
        else if (s inside {5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22})
          a = ACT_SCL_HI;
        else if (s inside {5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23})
          a = ACT_SHIFT_IN;
        else
          a = ACT_SCL_LO;
      end
      CMD_SEND_ACK: begin
        case (s)
          5'd0:    a = ACT_SDA_LSB;
          5'd1:    a = ACT_SCL_HI;
          default: a = ACT_SCL_LO;
        endcase
      end
      CMD_RECV_ACK: a = ack_act(s[1:0], 1'b0);
      default:      a = ACT_NONE;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[sv/i2cbs_front.sv]
// Front end: input handshake, command classification, request queue.
`default_nettype none

module i2cbs_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [2:0]                 in_tuser,
  input  wire logic [i2cbs_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                            q_valid,
  output i2cbs_pkg::req_t                 q_req,
  input  wire logic                       q_pop
);

  i2cbs_pkg::req_t                    q_r [i2cbs_pkg::QUEUE_DEPTH];
  logic [i2cbs_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [i2cbs_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [i2cbs_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  i2cbs_pkg::req_t                    req;
  logic                               push;
  logic                               pop;

  // classify: 1..6 are real commands, 7 is reserved
  always_comb begin
    req.kind        = i2cbs_pkg::cmd_t'(in_tuser);
    req.is_cmd      = (req.kind != i2cbs_pkg::CMD_NONE) && (req.kind != i2cbs_pkg::CMD_RSVD);
    req.tx_byte     = in_tdata[7:0];
    req.ack_to_send = in_tdata[8];
    req.sda_in      = in_tdata[9];
  end

  assign in_tready = (cnt_r != i2cbs_pkg::QCNT_W'(i2cbs_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_req     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == i2cbs_pkg::QPTR_W'(i2cbs_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == i2cbs_pkg::QPTR_W'(i2cbs_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)
      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push)
      cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      q_r[wr_ptr_r] <= req;
  end

endmodule

`default_nettype wire

[sv/i2cbs_back.sv]
// Back end: command sequencer, pin/ack state and result register.
`default_nettype none
`include "assert_macros.svh"

module i2cbs_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire i2cbs_pkg::req_t                   q_req,
  output logic                                   q_pop,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [i2cbs_pkg::TICK_W-1:0]      cfg_data,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [i2cbs_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  i2cbs_pkg::cmd_t                 active_r, active_nxt;
  logic [i2cbs_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [i2cbs_pkg::TICK_W-1:0]    tick_r, tick_nxt;
  logic [7:0]                      shift_r, shift_nxt;
  logic [7:0]                      rx_r, rx_nxt;
  logic                            scl_r, scl_nxt;
  logic                            sda_r, sda_nxt;
  logic                            acked_r, acked_nxt;
  logic                            ackseen_r, ackseen_nxt;
  logic [i2cbs_pkg::TICK_W-1:0]    step_ticks_r;
  logic                            out_valid_r;
  i2cbs_pkg::res_t                 out_r;
  i2cbs_pkg::res_t                 res;

  logic                            start_cmd;
  i2cbs_pkg::cmd_t                 cmd_cur;
  logic [i2cbs_pkg::STEP_W-1:0]    step_cur;
  logic [i2cbs_pkg::TICK_W-1:0]    tick_cur;
  logic [i2cbs_pkg::TICK_W:0]      tick_inc;
  logic [i2cbs_pkg::TICK_W-1:0]    limit;
  logic [i2cbs_pkg::STEP_W-1:0]    step_inc;
  logic                            running;
  logic                            step_wrap;
  logic                            seq_end;
  logic [7:0]                      shift_ld;
  i2cbs_pkg::act_t                 act;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_valid && (!out_valid_r || out_tready);

  assign limit     = (step_ticks_r == '0) ? i2cbs_pkg::TICK_W'(1) : step_ticks_r;
  assign start_cmd = (active_r == i2cbs_pkg::CMD_NONE) && q_req.is_cmd;
  assign cmd_cur   = start_cmd ? q_req.kind : active_r;
  assign step_cur  = start_cmd ? '0 : step_r;
  assign tick_cur  = start_cmd ? '0 : tick_r;
  assign running   = (cmd_cur != i2cbs_pkg::CMD_NONE);
  assign tick_inc  = {1'b0, tick_cur} + 1'b1;
  assign step_inc  = step_cur + 1'b1;
  assign step_wrap = running && (tick_inc >= {1'b0, limit});
  assign seq_end   = step_wrap && (step_inc >= i2cbs_pkg::seq_len(cmd_cur));
  assign act       = (running && tick_cur == '0) ?
                     i2cbs_pkg::step_act(cmd_cur, step_cur) : i2cbs_pkg::ACT_NONE;

  // next state
  always_comb begin
    active_nxt = active_r;
    if (q_pop) begin
      if (seq_end)
        active_nxt = i2cbs_pkg::CMD_NONE;
      else
        active_nxt = cmd_cur;
    end
  end

  // datapath and result
  always_comb begin
    step_nxt    = step_r;
    tick_nxt    = tick_r;
    shift_nxt   = shift_r;
    rx_nxt      = rx_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    acked_nxt   = acked_r;
    ackseen_nxt = ackseen_r;

    shift_ld = shift_r;
    if (start_cmd) begin
      case (q_req.kind)
        i2cbs_pkg::CMD_WRITE:    shift_ld = q_req.tx_byte;
        i2cbs_pkg::CMD_SEND_ACK: shift_ld = {7'd0, q_req.ack_to_send};
        i2cbs_pkg::CMD_READ:     shift_ld = '0;
        default:                 shift_ld = shift_r;
      endcase
    end

    if (q_pop) begin
      shift_nxt = shift_ld;
      case (act)
        i2cbs_pkg::ACT_SCL_HI:   scl_nxt = 1'b1;
        i2cbs_pkg::ACT_SCL_LO:   scl_nxt = 1'b0;
        i2cbs_pkg::ACT_SDA_HI:   sda_nxt = 1'b1;
        i2cbs_pkg::ACT_SDA_LO:   sda_nxt = 1'b0;
        i2cbs_pkg::ACT_SDA_MSB: begin
          sda_nxt   = shift_ld[7];
          shift_nxt = {shift_ld[6:0], 1'b0};
        end
        i2cbs_pkg::ACT_SDA_LSB:  sda_nxt = shift_ld[0];
        i2cbs_pkg::ACT_SHIFT_IN: shift_nxt = {shift_ld[6:0], q_req.sda_in};
        i2cbs_pkg::ACT_SAMPLE_ACK: ackseen_nxt = q_req.sda_in;
        i2cbs_pkg::ACT_SAMPLE_WACK: begin
          ackseen_nxt = q_req.sda_in;
          acked_nxt   = !q_req.sda_in;
        end
        default: ;
      endcase

      if (running) begin
        if (step_wrap) begin
          tick_nxt = '0;
          step_nxt = seq_end ? '0 : step_inc;
        end else begin
          tick_nxt = tick_inc[i2cbs_pkg::TICK_W-1:0];
          step_nxt = step_cur;
        end
      end
      if (seq_end && cmd_cur == i2cbs_pkg::CMD_READ)
        rx_nxt = shift_nxt;
    end

    res.scl_level    = scl_nxt;
    res.sda_level    = sda_nxt;
    res.busy_res     = (active_nxt != i2cbs_pkg::CMD_NONE);
    res.done_res     = seq_end;
    res.rx_byte      = rx_nxt;
    res.acked        = acked_nxt;
    res.ack_bit_seen = ackseen_nxt;
    res.rejected     = (active_r != i2cbs_pkg::CMD_NONE) &&
                       (q_req.kind != i2cbs_pkg::CMD_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= i2cbs_pkg::CMD_NONE;
      step_r       <= '0;
      tick_r       <= '0;
      shift_r      <= '0;
      rx_r         <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      acked_r      <= 1'b0;
      ackseen_r    <= 1'b0;
      step_ticks_r <= i2cbs_pkg::STEP_TICKS_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      step_r    <= step_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      rx_r      <= rx_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      acked_r   <= acked_nxt;
      ackseen_r <= ackseen_nxt;
      if (cfg_valid && cfg_ready)
        step_ticks_r <= cfg_data;
      if (q_pop)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)
      out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(i2cbs_pkg::OUT_TDATA_W - $bits(i2cbs_pkg::res_t)){1'b0}}, out_r};

  // idle sequencer holds step and tick counters at zero
  `ASSERT_IMPLY(a_idle_cnt_zero, clk, rst_n, active_r == i2cbs_pkg::CMD_NONE, step_r == '0 && tick_r == '0)
  // running step index stays inside the command's sequence
  `ASSERT_IMPLY(a_step_in_seq, clk, rst_n, active_r != i2cbs_pkg::CMD_NONE, step_r < i2cbs_pkg::seq_len(active_r))
  // reserved code never becomes the active command
  `ASSERT_IMPLY(a_no_rsvd_cmd, clk, rst_n, 1'b1, active_r != i2cbs_pkg::CMD_RSVD)
  // a finishing tick leaves the sequencer idle
  `ASSERT_NEXT(a_done_idle, clk, rst_n, q_pop && seq_end, active_r == i2cbs_pkg::CMD_NONE)

endmodule

`default_nettype wire

[sv/i2c_master_bit_sequencer_core.sv]
// Top level of the I2C master bit sequencer.
//
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   tuser: kind; tdata: tx_byte, ack_to_send, sda_in
// out_     out  out_tvalid/tready  tdata: scl, sda, busy, done, rx_byte, acked,
//                                  ack_bit_seen, rejected
// cfg_     in   cfg_valid/ready    cfg_data: step_ticks
//
// One request per cycle sustained while out_tready stays high; an accepted request is
// written into the queue, then the sequencer update moves it into the result register.
// The front queue holds two requests; in_tready drops only when it is full,
// i.e. when out_tready has been low long enough to back up the sequencer.
// The sequencer advances only when a request leaves the queue, so each
// request is exactly one bus-timing tick regardless of stalls.
// Synchronous active-low reset: pins released, step_ticks = 10, queue empty.
// cfg_ready is always high; step_ticks takes effect on the next request.
`default_nettype none

module i2c_master_bit_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,    // [2:0] kind
  input  wire logic [15:0] in_tdata,    // [7:0] tx_byte, [8] ack_to_send, [9] sda_in
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                        // [3] done_res, [11:4] rx_byte, [12] acked,
                                        // [13] ack_bit_seen, [14] rejected
  // step timing register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);

  logic            q_valid;
  logic            q_pop;
  i2cbs_pkg::req_t q_req;

  // front: accept and classify requests into the queue
  i2cbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop)
  );

  // back: step sequencer, pin state and result register
  i2cbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[verif/i2c_master_bit_sequencer_core_tb.sv]
// Self-checking testbench for the I2C master bit sequencer core: bus ticks vs. a pin model.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_tb;

  // Quiet cycles (no request and no result moving) before the run is declared hung.
  // The slowest stretch is a few back-to-back receiver stalls or a config pause,
  // so this limit is far beyond any correct run.
  localparam int unsigned STALL_LIMIT = 5000;
  // Extra wait after the last owed result has come back, before a config write.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_TICKS = 200;
  // Idle chance per cycle on either side, in percent.
  localparam int unsigned IDLE_PCT = 12;
  // SDA source while a command runs.
  localparam int SDA_LOW = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RANDOM = 2;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;     // [2:0] kind
  logic [15:0] in_tdata = '0;     // [7:0] tx_byte, [8] ack_to_send, [9] sda_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [0] scl, [1] sda, [2] busy, [3] done, [11:4] rx_byte,
                                  // [12] acked, [13] ack_bit_seen, [14] rejected
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;

  // Both sides run without gaps while this is set.
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned quiet_cycles = 0;

  // Pin states the block owes us, oldest first; one per accepted request.
  i2cbs_pkg::res_t bus_results_due[$];

  // Sequencer model state.
  i2cbs_pkg::cmd_t seq_cmd;
  logic [4:0]  seq_step;
  int unsigned seq_ticks;
  logic [7:0]  seq_shift;
  logic [7:0]  seq_rx;
  logic        pin_scl;
  logic        pin_sda;
  logic        flag_acked;
  logic        flag_ack_seen;
  logic [9:0]  step_hold;

  i2c_master_bit_sequencer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Ack slot shared by write (with acked update) and receive ack (ack_bit_seen only).
  function automatic void ack_step(int unsigned ph, logic sda, logic from_write);
    case (ph)
      0: pin_sda = 1'b1;
      1: pin_scl = 1'b1;
      2: begin
        flag_ack_seen = sda;
        if (from_write) flag_acked = ~sda;
      end
      default: pin_scl = 1'b0;
    endcase
  endfunction

  // One bus tick: start a command if idle, run the step action on the first tick
  // of each step, advance the tick/step counters and report the pins and flags.
  function automatic i2cbs_pkg::res_t model_bus_tick(logic [2:0] kind, logic [7:0] tx,
                                                     logic ackv, logic sda);
    i2cbs_pkg::res_t r;
    int unsigned hold;
    int unsigned s;
    int unsigned nsteps;
    r = '0;
    // a hold of zero ticks behaves as one
    hold = (step_hold == 10'd0) ? 1 : step_hold;
    if (seq_cmd == i2cbs_pkg::CMD_NONE) begin
      // reserved kind while idle: silently dropped, not flagged
      if (kind != i2cbs_pkg::CMD_NONE && kind != i2cbs_pkg::CMD_RSVD) begin
        seq_cmd = i2cbs_pkg::cmd_t'(kind);
        seq_step = '0;
        seq_ticks = 0;
        case (seq_cmd)
          i2cbs_pkg::CMD_WRITE:    seq_shift = tx;
          i2cbs_pkg::CMD_SEND_ACK: seq_shift = {7'd0, ackv};
          i2cbs_pkg::CMD_READ:     seq_shift = 8'd0;
          default: ;
        endcase
      end
    end else if (kind != i2cbs_pkg::CMD_NONE) begin
      // any command while busy, reserved kind too, is dropped and flagged
      r.rejected = 1'b1;
    end

    if (seq_cmd != i2cbs_pkg::CMD_NONE) begin
      s = seq_step;
      if (seq_ticks == 0) begin
        case (seq_cmd)
          i2cbs_pkg::CMD_START: begin
            case (s)
              0:       pin_sda = 1'b1;
              1:       pin_scl = 1'b1;
              2:       pin_sda = 1'b0;
              default: pin_scl = 1'b0;
            endcase
          end
          i2cbs_pkg::CMD_STOP: begin
            case (s)
              0:       pin_sda = 1'b0;
              1:       pin_scl = 1'b1;
              default: pin_sda = 1'b1;
            endcase
          end
          i2cbs_pkg::CMD_WRITE: begin
            if (s < 24) begin
              case (s % 3)
                0:       pin_sda = seq_shift[7 - s / 3];
                1:       pin_scl = 1'b1;
                default: pin_scl = 1'b0;
              endcase
            end else begin
              ack_step(s - 24, sda, 1'b1);
            end
          end
          i2cbs_pkg::CMD_READ: begin
            if (s == 0) begin
              pin_sda = 1'b1;
            end else begin
              case ((s - 1) % 3)
                0:       pin_scl = 1'b1;
                1:       seq_shift = {seq_shift[6:0], sda};
                default: pin_scl = 1'b0;
              endcase
            end
          end
          i2cbs_pkg::CMD_SEND_ACK: begin
            case (s)
              0:       pin_sda = seq_shift[0];
              1:       pin_scl = 1'b1;
              default: pin_scl = 1'b0;
            endcase
          end
          default: ack_step(s % 4, sda, 1'b0);
        endcase
      end
      seq_ticks++;
      if (seq_ticks >= hold) begin
        seq_ticks = 0;
        seq_step++;
        case (seq_cmd)
          i2cbs_pkg::CMD_START, i2cbs_pkg::CMD_RECV_ACK: nsteps = 4;
          i2cbs_pkg::CMD_STOP, i2cbs_pkg::CMD_SEND_ACK:  nsteps = 3;
          i2cbs_pkg::CMD_WRITE:                          nsteps = 28;
          default:                                       nsteps = 25;
        endcase
        if (seq_step >= nsteps) begin
          if (seq_cmd == i2cbs_pkg::CMD_READ) seq_rx = seq_shift;
          seq_cmd = i2cbs_pkg::CMD_NONE;
          seq_step = '0;
          r.done_res = 1'b1;
        end
      end
    end

    r.scl_level = pin_scl;
    r.sda_level = pin_sda;
    r.busy_res = (seq_cmd != i2cbs_pkg::CMD_NONE);
    r.rx_byte = seq_rx;
    r.acked = flag_acked;
    r.ack_bit_seen = flag_ack_seen;
    return r;
  endfunction

  // Send one tick request; random gaps before it unless calm. The model runs at the
  // accepting edge so the expectation is queued in request order.
  task automatic send_tick(logic [2:0] kind, logic [7:0] tx, logic ackv, logic sda);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'd0, sda, ackv, tx};
    do @(posedge clk); while (!in_tready);
    bus_results_due.push_back(model_bus_tick(kind, tx, ackv, sda));
    ticks_sent++;
  endtask

  // Feed plain ticks until the running command ends; now and then a stray command.
  task automatic finish_command(int sda_mode, int unsigned reject_pct);
    logic [2:0] k;
    logic       sda;
    while (seq_cmd != i2cbs_pkg::CMD_NONE) begin
      k = ($urandom_range(99) < reject_pct) ? 3'($urandom_range(1, 7)) : i2cbs_pkg::CMD_NONE;
      sda = (sda_mode == SDA_RANDOM) ? 1'($urandom) : 1'(sda_mode);
      send_tick(k, 8'($urandom), 1'($urandom), sda);
    end
  endtask

  task automatic run_command(i2cbs_pkg::cmd_t cmd, logic [7:0] tx, logic ackv, int sda_mode,
                             int unsigned reject_pct);
    send_tick(cmd, tx, ackv, (sda_mode == SDA_RANDOM) ? 1'($urandom) : 1'(sda_mode));
    finish_command(sda_mode, reject_pct);
  endtask

  // Stop requests and let every owed result come back, plus the pipeline latency.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_step_ticks(logic [9:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_hold = v;
  endtask

  // Power-up hold of 10 ticks per step, before any register write.
  task automatic test_reset_defaults();
    send_tick(i2cbs_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1);
    run_command(i2cbs_pkg::CMD_START, 8'hFF, 1'b1, SDA_RANDOM, 0);
    send_tick(i2cbs_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b0);
  endtask

  // Every command at one tick per step, with the data extremes.
  task automatic test_each_command();
    set_step_ticks(10'd1);
    run_command(i2cbs_pkg::CMD_START, 8'h00, 1'b0, SDA_HIGH, 0);
    run_command(i2cbs_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);   // slave acks
    run_command(i2cbs_pkg::CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 0);  // slave nacks
    run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, SDA_HIGH, 0);   // all ones
    run_command(i2cbs_pkg::CMD_READ, 8'hFF, 1'b1, SDA_LOW, 0);    // all zeros
    run_command(i2cbs_pkg::CMD_READ, 8'h3C, 1'b0, SDA_RANDOM, 0);
    run_command(i2cbs_pkg::CMD_SEND_ACK, 8'hFF, 1'b0, SDA_HIGH, 0);
    run_command(i2cbs_pkg::CMD_SEND_ACK, 8'h00, 1'b1, SDA_LOW, 0);
    run_command(i2cbs_pkg::CMD_RECV_ACK, 8'h81, 1'b1, SDA_LOW, 0);
    run_command(i2cbs_pkg::CMD_STOP, 8'h7E, 1'b0, SDA_HIGH, 0);
    // multi-tick steps: action only on the first tick of each step
    set_step_ticks(10'd3);
    run_command(i2cbs_pkg::CMD_WRITE, 8'hA5, 1'b1, SDA_RANDOM, 0);
  endtask

  task automatic test_special_cases();
    set_step_ticks(10'd1);
    // reserved kind while idle is ignored and not flagged
    send_tick(i2cbs_pkg::CMD_RSVD, 8'h55, 1'b1, 1'b1);
    send_tick(i2cbs_pkg::CMD_RSVD, 8'hAA, 1'b0, 1'b0);
    // every kind while busy is flagged and the write carries on
    send_tick(i2cbs_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0);
    for (int k = 1; k <= 7; k++) send_tick(3'(k), 8'h5A, 1'b1, 1'b0);
    finish_command(SDA_LOW, 0);
    // lone receive ack moves ack_bit_seen, acked holds from the write
    run_command(i2cbs_pkg::CMD_RECV_ACK, 8'h00, 1'b0, SDA_HIGH, 0);
    // zero hold counts as one tick
    set_step_ticks(10'd0);
    run_command(i2cbs_pkg::CMD_SEND_ACK, 8'h01, 1'b1, SDA_RANDOM, 0);
    run_command(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 5);
  endtask

  // Long hold: a stop keeps each pin state for 20 ticks.
  task automatic test_slow_steps();
    set_step_ticks(10'd20);
    run_command(i2cbs_pkg::CMD_STOP, 8'hC3, 1'b0, SDA_RANDOM, 2);
  endtask

  // Mostly well-formed bus transfers (start, address, data, stop) with random data
  // and short holds; some stray command runs and idle/reserved ticks in between.
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned n;
    int unsigned nbytes;
    logic [7:0]  addr;
    first = ticks_sent;
    while (ticks_sent - first < RANDOM_TICKS) begin
      n = ticks_sent - first;
      calm = (n >= 60 && n < 160);
      case ($urandom_range(9))
        0:       set_step_ticks(10'd0);
        1:       set_step_ticks(10'd2);
        2:       set_step_ticks(10'($urandom_range(3, 5)));
        default: set_step_ticks(10'd1);
      endcase
      repeat ($urandom_range(0, 2))
        send_tick(($urandom_range(2) == 0) ? i2cbs_pkg::CMD_RSVD : i2cbs_pkg::CMD_NONE,
                  8'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(9) < 8) begin
        addr = 8'($urandom);
        nbytes = $urandom_range(1, 3);
        run_command(i2cbs_pkg::CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 4);
        run_command(i2cbs_pkg::CMD_WRITE, addr, 1'($urandom), SDA_RANDOM, 4);
        for (int i = 0; i < nbytes; i++) begin
          if (addr[0]) begin
            run_command(i2cbs_pkg::CMD_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 4);
            // master nacks the last byte
            run_command(i2cbs_pkg::CMD_SEND_ACK, 8'($urandom), (i == nbytes - 1),
                        SDA_RANDOM, 4);
          end else begin
            run_command(i2cbs_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 4);
          end
        end
        run_command(i2cbs_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 4);
      end else begin
        repeat ($urandom_range(2, 4))
          run_command(i2cbs_pkg::cmd_t'($urandom_range(1, 6)), 8'($urandom), 1'($urandom),
                      SDA_RANDOM, 8);
      end
    end
    calm = 1'b0;
  endtask

  // Receiver side: random back-pressure unless calm.
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Every result is checked against the oldest owed pin state, field by field.
  always @(posedge clk) begin
    i2cbs_pkg::res_t got;
    i2cbs_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = i2cbs_pkg::res_t'(out_tdata[14:0]);
      if (bus_results_due.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = bus_results_due.pop_front();
        check_field("scl_level", want.scl_level, got.scl_level);
        check_field("sda_level", want.sda_level, got.sda_level);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("acked", want.acked, got.acked);
        check_field("ack_bit_seen", want.ack_bit_seen, got.ack_bit_seen);
        check_field("rejected", want.rejected, got.rejected);
        check_field("pad", 0, out_tdata[15]);
      end
    end
  end

  // Hang detector: nothing accepted on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("i2c_master_bit_sequencer_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // model starts from the reset state: idle, pins released, 10 ticks per step
    seq_cmd = i2cbs_pkg::CMD_NONE;
    seq_step = '0;
    seq_ticks = 0;
    seq_shift = '0;
    seq_rx = '0;
    pin_scl = 1'b1;
    pin_sda = 1'b1;
    flag_acked = 1'b0;
    flag_ack_seen = 1'b0;
    step_hold = i2cbs_pkg::STEP_TICKS_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_each_command();
    test_special_cases();
    test_slow_steps();
    test_random_traffic();
    wait_idle();

    if (mismatches == 0) begin
      $display("i2c_master_bit_sequencer_core verification clean");
    end else begin
      $display("i2c_master_bit_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
